// ===== rtl/smnq_pkg.sv =====
`timescale 1ns / 1ps

package smnq_pkg;

    localparam int MAX_CELLS_PER_AXIS = 1024;
    localparam int DIM_W  = 11;
    localparam int ID_W   = 31;
    localparam int NID_W  = 32;
    localparam int COORD_W = DIM_W + 1;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_CELLS_X = 2'd0;
    localparam logic [1:0] CFG_CELLS_Y = 2'd1;
    localparam logic [1:0] CFG_CELLS_Z = 2'd2;

    // Query codes.
    localparam logic [2:0] ACT_CELL_FACES = 3'd0;
    localparam logic [2:0] ACT_FACE_EDGES = 3'd1;
    localparam logic [2:0] ACT_FACE_CELLS = 3'd2;
    localparam logic [2:0] ACT_EDGE_FACES = 3'd3;
    localparam logic [2:0] ACT_EDGE_CELLS = 3'd4;

    typedef enum logic [1:0] {
        KIND_CELL = 2'd0,
        KIND_FACE = 2'd1,
        KIND_EDGE = 2'd2
    } kind_t;

    typedef logic [2:0][DIM_W-1:0] dim3_t;

    // One neighbour: what it is and how it sits relative to the query.
    typedef struct packed {
        kind_t      kind;
        logic [1:0] ax;
        logic [2:0] dm;
        logic [2:0] dp;
    } slot_dec_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_CELLS_PER_AXIS))
        begin
            r = DIM_W'(MAX_CELLS_PER_AXIS);
        end
        return r;
    endfunction

    function automatic dim3_t shape_of(input kind_t kind, input logic [1:0] ax,
                                       input dim3_t d);
        dim3_t s;
        s = d;
        for (int k = 0; k < 3; k++)
        begin
            if (kind == KIND_FACE && ax == 2'(k))
            begin
                s[k] = d[k] + DIM_W'(1);
            end
            if (kind == KIND_EDGE && ax != 2'(k))
            begin
                s[k] = d[k] + DIM_W'(1);
            end
        end
        return s;
    endfunction

    function automatic kind_t kind_of(input logic [2:0] action);
        kind_t k;
        case (action)
            ACT_CELL_FACES:                 k = KIND_CELL;
            ACT_FACE_EDGES, ACT_FACE_CELLS: k = KIND_FACE;
            default:                        k = KIND_EDGE;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] run_len(input logic [2:0] action);
        logic [2:0] n;
        unique case (action)
            ACT_CELL_FACES: n = 3'd6;
            ACT_FACE_EDGES: n = 3'd4;
            ACT_FACE_CELLS: n = 3'd2;
            ACT_EDGE_FACES: n = 3'd4;
            ACT_EDGE_CELLS: n = 3'd4;
            default:        n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] next_axis(input logic [1:0] a);
        return (a == 2'd2) ? 2'd0 : a + 2'd1;
    endfunction

    function automatic logic [2:0] bit_of(input logic [1:0] a);
        return 3'b001 << a;
    endfunction

    // a is the zero-based axis of the queried face or edge.
    function automatic slot_dec_t slot_decode(input logic [2:0] action, input logic [1:0] a,
                                              input logic [2:0] slot);
        slot_dec_t  r;
        logic [1:0] b;
        logic [1:0] c;
        b = next_axis(a);
        c = next_axis(b);
        r.kind = KIND_CELL;
        r.ax   = 2'd0;
        r.dm   = 3'b000;
        r.dp   = 3'b000;
        unique case (action)
            ACT_CELL_FACES:
            begin
                r.kind = KIND_FACE;
                r.ax   = slot[2:1];
                r.dp   = slot[0] ? bit_of(slot[2:1]) : 3'b000;
            end
            ACT_FACE_EDGES:
            begin
                r.kind = KIND_EDGE;
                r.ax   = slot[1] ? c : b;
                if (slot[0])
                begin
                    r.dp = slot[1] ? bit_of(b) : bit_of(c);
                end
            end
            ACT_FACE_CELLS:
            begin
                r.dm = slot[0] ? 3'b000 : bit_of(a);
            end
            ACT_EDGE_FACES:
            begin
                r.kind = KIND_FACE;
                r.ax   = slot[1] ? c : b;
                if (!slot[0])
                begin
                    r.dm = slot[1] ? bit_of(b) : bit_of(c);
                end
            end
            ACT_EDGE_CELLS:
            begin
                r.dm = (slot[0] ? 3'b000 : bit_of(b)) | (slot[1] ? 3'b000 : bit_of(c));
            end
            default:
            begin
                r.kind = KIND_CELL;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/smnq_if.sv =====
`timescale 1ns / 1ps

interface smnq_req_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      action;
    logic [1:0]                      axis;
    logic [smnq_pkg::ID_W-1:0]       entity_id;

    modport source (output valid, action, axis, entity_id, input ready);
    modport sink   (input valid, action, axis, entity_id, output ready);
endinterface

interface smnq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic signed [smnq_pkg::NID_W-1:0] neighbour_id;
    logic [1:0]                      neighbour_axis;
    logic [2:0]                      slot;
    logic [2:0]                      valid_count;
    logic                            bad_request;
    logic                            last;

    modport source (output valid, neighbour_id, neighbour_axis, slot, valid_count,
                    bad_request, last, input ready);
    modport sink   (input valid, neighbour_id, neighbour_axis, slot, valid_count,
                    bad_request, last, output ready);
endinterface

// ===== rtl/staggered_mesh_neighbor_query.sv =====
`timescale 1ns / 1ps
// Throughput: one response beat per cycle while the response channel is not stalled.
// A request yields one beat per neighbour (6 for cell faces, 4 for face edges, edge
// faces and edge cells, 2 for face cells, 1 for an unknown query); a new request is
// accepted only when the serializer is empty or on the last neighbour of the one before.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and sets the
// three cell counts to 1.

module staggered_mesh_neighbor_query (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [smnq_pkg::DIM_W-1:0]    cfg_data,
    smnq_req_if.sink                      req,
    smnq_rsp_if.source                    rsp
);
    import smnq_pkg::*;

    // Front end stages: 0 captures the request, 1 and 2 form the entity count,
    // 3 flags an id past the end, 4..14 produce one bit each of the first coordinate
    // and 15..25 one bit each of the second; the remainder is the third coordinate.
    localparam int NFE       = 26;
    localparam int DIV1_LAST = 14;
    localparam int DIV2_LAST = 25;

    typedef struct packed {
        logic [2:0]        action;
        logic [1:0]        axis;
        logic              bad;
        dim3_t             s;
        logic [2*DIM_W-1:0] p12;
        logic [31:0]       total;
        logic [ID_W-1:0]   rem;
        logic [DIM_W-1:0]  q0;
        logic [DIM_W-1:0]  q1;
    } fe_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [1:0]        axis;
        logic              bad;
        logic [DIM_W-1:0]  i0;
        logic [DIM_W-1:0]  i1;
        logic [DIM_W-1:0]  i2;
    } ser_t;

    typedef struct packed {
        logic                             bad;
        logic                             last;
        logic [2:0]                       slot;
        logic [1:0]                       nax;
        logic [2:0][COORD_W-1:0]          j;
        dim3_t                            t;
    } b0_t;

    typedef struct packed {
        logic                bad;
        logic                last;
        logic [2:0]          slot;
        logic [1:0]          nax;
        logic                inb;
        logic [2:0]          cnt;
        logic [2*DIM_W-1:0]  m;
        logic [DIM_W-1:0]    j2;
        logic [DIM_W-1:0]    t2;
    } b1_t;

    // Configuration registers and their clamped view.
    logic [DIM_W-1:0] dim_reg [3];
    dim3_t            dims;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dim_reg[k] <= DIM_W'(1);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CELLS_X: dim_reg[0] <= cfg_data;
                CFG_CELLS_Y: dim_reg[1] <= cfg_data;
                CFG_CELLS_Z: dim_reg[2] <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dims[k] = clamp_dim(dim_reg[k]);
        end
    end

    // Flow control. The back end and the output register move together whenever
    // the output beat is free or being taken. The serializer spends one back-end
    // beat per neighbour and pulls a new front-end item when empty or on its final beat.
    logic back_en;
    logic fe_en;
    logic ser_valid_reg;
    logic ser_last;

    assign back_en   = !rsp.valid || rsp.ready;
    assign fe_en     = back_en && (!ser_valid_reg || ser_last);
    assign req.ready = fe_en;

    // Front end pipeline.
    fe_t  fe_reg  [NFE];
    fe_t  fe_next [NFE];
    logic fe_valid_reg [NFE];

    always_comb
    begin
        kind_t      k0;
        logic [1:0] a0;
        k0 = kind_of(req.action);
        a0 = req.axis - 2'd1;
        fe_next[0]        = '0;
        fe_next[0].action = req.action;
        fe_next[0].axis   = req.axis;
        fe_next[0].bad    = (req.action > ACT_EDGE_CELLS) ||
                            (k0 != KIND_CELL && req.axis == 2'd0);
        fe_next[0].s      = shape_of(k0, a0, dims);
        fe_next[0].rem    = req.entity_id;
    end

    for (genvar g = 1; g < NFE; g++)
    begin : g_fe
        if (g == 1)
        begin : g_mul1
            always_comb
            begin
                fe_next[g]     = fe_reg[g-1];
                fe_next[g].p12 = fe_reg[g-1].s[1] * fe_reg[g-1].s[2];
            end
        end
        else if (g == 2)
        begin : g_mul2
            always_comb
            begin
                fe_next[g]       = fe_reg[g-1];
                fe_next[g].total = 32'(fe_reg[g-1].p12) * 32'(fe_reg[g-1].s[0]);
            end
        end
        else if (g == 3)
        begin : g_range
            always_comb
            begin
                fe_next[g]     = fe_reg[g-1];
                fe_next[g].bad = fe_reg[g-1].bad ||
                                 ({1'b0, fe_reg[g-1].rem} >= fe_reg[g-1].total);
            end
        end
        else if (g <= DIV1_LAST)
        begin : g_div1
            localparam int J = DIV1_LAST - g;
            logic [31:0] dsh;
            assign dsh = 32'(fe_reg[g-1].p12) << J;
            always_comb
            begin
                fe_next[g] = fe_reg[g-1];
                if ({1'b0, fe_reg[g-1].rem} >= dsh)
                begin
                    fe_next[g].rem   = fe_reg[g-1].rem - dsh[ID_W-1:0];
                    fe_next[g].q0[J] = 1'b1;
                end
            end
        end
        else
        begin : g_div2
            localparam int J = DIV2_LAST - g;
            logic [31:0] dsh;
            assign dsh = 32'(fe_reg[g-1].s[2]) << J;
            always_comb
            begin
                fe_next[g] = fe_reg[g-1];
                if ({1'b0, fe_reg[g-1].rem} >= dsh)
                begin
                    fe_next[g].rem   = fe_reg[g-1].rem - dsh[ID_W-1:0];
                    fe_next[g].q1[J] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NFE; k++)
            begin
                fe_valid_reg[k] <= 1'b0;
            end
        end
        else if (fe_en)
        begin
            fe_valid_reg[0] <= req.valid;
            for (int k = 1; k < NFE; k++)
            begin
                fe_valid_reg[k] <= fe_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe_en)
        begin
            for (int k = 0; k < NFE; k++)
            begin
                fe_reg[k] <= fe_next[k];
            end
        end
    end

    // Serializer: one neighbour per beat.
    ser_t       ser_reg;
    logic [2:0] slot_reg;
    logic [2:0] slot_next;

    assign ser_last  = (slot_reg == run_len(ser_reg.action) - 3'd1);
    assign slot_next = (fe_en) ? 3'd0 : slot_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            slot_reg      <= 3'd0;
        end
        else if (back_en)
        begin
            slot_reg <= slot_next;
            if (fe_en)
            begin
                ser_valid_reg <= fe_valid_reg[NFE-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe_en)
        begin
            ser_reg.action <= fe_reg[NFE-1].action;
            ser_reg.axis   <= fe_reg[NFE-1].axis;
            ser_reg.bad    <= fe_reg[NFE-1].bad;
            ser_reg.i0     <= fe_reg[NFE-1].q0;
            ser_reg.i1     <= fe_reg[NFE-1].q1;
            ser_reg.i2     <= fe_reg[NFE-1].rem[DIM_W-1:0];
        end
    end

    // Back end stage 0: neighbour coordinates and the neighbour's grid shape.
    b0_t       b0_reg;
    b0_t       b0_next;
    logic      b0_valid_reg;
    slot_dec_t sd;

    always_comb
    begin
        logic [2:0][DIM_W-1:0] ib;
        ib = {ser_reg.i2, ser_reg.i1, ser_reg.i0};
        sd = slot_decode(ser_reg.action, ser_reg.axis - 2'd1, slot_reg);
        b0_next.bad  = ser_reg.bad;
        b0_next.last = ser_last;
        b0_next.slot = slot_reg;
        b0_next.nax  = (ser_reg.bad || sd.kind == KIND_CELL) ? 2'd0 : sd.ax + 2'd1;
        for (int k = 0; k < 3; k++)
        begin
            b0_next.j[k] = {1'b0, ib[k]} + COORD_W'(sd.dp[k]) - COORD_W'(sd.dm[k]);
        end
        b0_next.t = shape_of(sd.kind, sd.ax, dims);
    end

    // Back end stage 1: bounds check, run count and the first multiply-add.
    b1_t        b1_reg;
    b1_t        b1_next;
    logic       b1_valid_reg;
    logic [2:0] run_cnt_reg;
    logic [2:0] run_cnt_next;

    always_comb
    begin
        logic inb;
        inb = !b0_reg.bad;
        for (int k = 0; k < 3; k++)
        begin
            if (b0_reg.j[k][COORD_W-1] || b0_reg.j[k][DIM_W-1:0] >= b0_reg.t[k])
            begin
                inb = 1'b0;
            end
        end
        b1_next.bad  = b0_reg.bad;
        b1_next.last = b0_reg.last;
        b1_next.slot = b0_reg.slot;
        b1_next.nax  = b0_reg.nax;
        b1_next.inb  = inb;
        b1_next.cnt  = run_cnt_reg + 3'(inb);
        b1_next.m    = b0_reg.j[0][DIM_W-1:0] * b0_reg.t[1]
                       + (2*DIM_W)'(b0_reg.j[1][DIM_W-1:0]);
        b1_next.j2   = b0_reg.j[2][DIM_W-1:0];
        b1_next.t2   = b0_reg.t[2];
        run_cnt_next = b0_reg.last ? 3'd0 : b1_next.cnt;
    end

    logic                      out_valid_reg;
    logic signed [NID_W-1:0]   out_id_reg;
    logic [1:0]                out_nax_reg;
    logic [2:0]                out_slot_reg;
    logic [2:0]                out_cnt_reg;
    logic                      out_bad_reg;
    logic                      out_last_reg;
    logic [NID_W-1:0]          id_next;

    assign id_next = NID_W'(b1_reg.m) * NID_W'(b1_reg.t2) + NID_W'(b1_reg.j2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_cnt_reg   <= 3'd0;
        end
        else if (back_en)
        begin
            b0_valid_reg  <= ser_valid_reg;
            b1_valid_reg  <= b0_valid_reg;
            out_valid_reg <= b1_valid_reg;
            if (b0_valid_reg)
            begin
                run_cnt_reg <= run_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            b0_reg       <= b0_next;
            b1_reg       <= b1_next;
            out_id_reg   <= b1_reg.inb ? $signed(id_next) : '1;
            out_nax_reg  <= b1_reg.nax;
            out_slot_reg <= b1_reg.slot;
            out_cnt_reg  <= b1_reg.last ? b1_reg.cnt : 3'd0;
            out_bad_reg  <= b1_reg.bad;
            out_last_reg <= b1_reg.last;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.neighbour_id   = out_id_reg;
    assign rsp.neighbour_axis = out_nax_reg;
    assign rsp.slot           = out_slot_reg;
    assign rsp.valid_count    = out_cnt_reg;
    assign rsp.bad_request    = out_bad_reg;
    assign rsp.last           = out_last_reg;

endmodule

// ===== rtl/smnq_checker.sv =====
`timescale 1ns / 1ps

module smnq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic signed [smnq_pkg::NID_W-1:0] rsp_neighbour_id,
    input logic [2:0]                    rsp_slot,
    input logic [2:0]                    rsp_valid_count,
    input logic                          rsp_bad_request,
    input logic                          rsp_last
);
    import smnq_pkg::*;

    logic [2:0] exp_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_slot_reg <= 3'd0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            exp_slot_reg <= rsp_last ? 3'd0 : rsp_slot + 3'd1;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_neighbour_id)
                                     && $stable(rsp_slot) && $stable(rsp_last))
        else $error("response beat changed while stalled");

    a_slot_seq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_slot == exp_slot_reg)
        else $error("response slot out of sequence");

    a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> rsp_valid_count == 3'd0)
        else $error("valid count on a beat that is not last");

    a_bad_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_bad_request |-> rsp_neighbour_id == -32'sd1
                                         && rsp_valid_count == 3'd0)
        else $error("flagged request reports a neighbour");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_last |-> rsp_valid_count <= rsp_slot + 3'd1)
        else $error("valid count exceeds run length");

endmodule

bind staggered_mesh_neighbor_query smnq_checker u_smnq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_neighbour_id (rsp.neighbour_id),
    .rsp_slot         (rsp.slot),
    .rsp_valid_count  (rsp.valid_count),
    .rsp_bad_request  (rsp.bad_request),
    .rsp_last         (rsp.last)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the staggered mesh neighbor query block.
// A driver streams query beats from a queue in random bursts; a monitor takes
// response beats under a random stall pattern and compares each one, field by
// field, against neighbor runs computed here from the current grid dimensions.
// The grid is reconfigured between phases, only when the block has drained.

module tb;
    import smnq_pkg::*;

    typedef struct packed {
        logic [2:0]      action;
        logic [1:0]      axis;
        logic [ID_W-1:0] entity_id;
    } query_t;

    typedef struct packed {
        logic signed [NID_W-1:0] nid;
        logic [1:0]              nax;
        logic [2:0]              slot;
        logic [2:0]              vcount;
        logic                    bad;
        logic                    last;
    } nbr_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [DIM_W-1:0] cfg_data;

    smnq_req_if req ();
    smnq_rsp_if rsp ();

    staggered_mesh_neighbor_query DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Grid dimensions as last written, raw; the predictor applies clamping.
    logic [DIM_W-1:0] grid_x = DIM_W'(1), grid_y = DIM_W'(1), grid_z = DIM_W'(1);

    query_t pending_queries[$];
    nbr_t   expected_nbrs[$];
    int     mismatches = 0;
    int     beats_checked = 0;
    int     queries_sent = 0;
    bit     stim_done = 0;

    function automatic longint eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_CELLS_PER_AXIS) return MAX_CELLS_PER_AXIS;
        return longint'(v);
    endfunction

    // kind selects a cell (0), a face (1) or an edge (2); ax is zero-based.
    function automatic void entity_shape(input int kind, input int ax, output longint s[3]);
        s[0] = eff_dim(grid_x);
        s[1] = eff_dim(grid_y);
        s[2] = eff_dim(grid_z);
        for (int k = 0; k < 3; k++)
        begin
            if (kind == 1 && k == ax) s[k] += 1;
            if (kind == 2 && k != ax) s[k] += 1;
        end
    endfunction

    // Id of the entity at base + o1 on d1 + o2 on d2, or -1 when outside.
    function automatic logic [31:0] nbr_id(input int kind, input int ax, input longint base[3],
                                           input int d1, input int o1, input int d2,
                                           input int o2);
        longint s[3];
        longint p[3];
        entity_shape(kind, ax, s);
        p = base;
        p[d1] += o1;
        p[d2] += o2;
        for (int k = 0; k < 3; k++)
            if (p[k] < 0 || p[k] >= s[k]) return 32'hFFFF_FFFF;
        return 32'((p[0] * s[1] + p[1]) * s[2] + p[2]);
    endfunction

    // Appends the expected neighbor run of one query.
    task automatic predict_neighbors(input query_t q);
        int         n, kind, a, b, c, valid;
        bit         bad;
        longint     s[3];
        longint     pos[3];
        longint     r;
        logic [31:0] ids[6];
        logic [1:0]  axes[6];
        nbr_t        e;
        a = 0; b = 1; c = 2; valid = 0;
        pos = '{0, 0, 0};
        if (q.action > ACT_EDGE_CELLS)
        begin
            e = '{nid: -1, nax: 0, slot: 0, vcount: 0, bad: 1, last: 1};
            expected_nbrs.push_back(e);
            return;
        end
        case (q.action)
            ACT_CELL_FACES: n = 6;
            ACT_FACE_CELLS: n = 2;
            default:        n = 4;
        endcase
        kind = (q.action == ACT_CELL_FACES) ? 0 : (q.action <= ACT_FACE_CELLS ? 1 : 2);
        bad = (kind != 0 && q.axis == 0);
        if (!bad)
        begin
            if (kind != 0)
            begin
                a = int'(q.axis) - 1;
                b = (a + 1) % 3;
                c = (a + 2) % 3;
            end
            entity_shape(kind, a, s);
            if (longint'(q.entity_id) >= s[0] * s[1] * s[2])
                bad = 1;
            else
            begin
                r = longint'(q.entity_id);
                pos[0] = r / (s[1] * s[2]);
                r -= pos[0] * s[1] * s[2];
                pos[1] = r / s[2];
                pos[2] = r - pos[1] * s[2];
            end
        end
        for (int k = 0; k < 6; k++)
        begin
            ids[k] = 32'hFFFF_FFFF;
            axes[k] = 2'd0;
        end
        if (!bad)
        begin
            case (q.action)
                ACT_CELL_FACES:
                    for (int k = 0; k < 3; k++)
                    begin
                        ids[2*k] = nbr_id(1, k, pos, k, 0, k, 0);
                        ids[2*k+1] = nbr_id(1, k, pos, k, 1, k, 0);
                        axes[2*k] = 2'(k + 1);
                        axes[2*k+1] = 2'(k + 1);
                    end
                ACT_FACE_EDGES:
                begin
                    ids[0] = nbr_id(2, b, pos, c, 0, c, 0);
                    ids[1] = nbr_id(2, b, pos, c, 1, c, 0);
                    ids[2] = nbr_id(2, c, pos, b, 0, b, 0);
                    ids[3] = nbr_id(2, c, pos, b, 1, b, 0);
                end
                ACT_FACE_CELLS:
                begin
                    ids[0] = nbr_id(0, 0, pos, a, -1, a, 0);
                    ids[1] = nbr_id(0, 0, pos, a, 0, a, 0);
                end
                ACT_EDGE_FACES:
                begin
                    ids[0] = nbr_id(1, b, pos, c, -1, c, 0);
                    ids[1] = nbr_id(1, b, pos, c, 0, c, 0);
                    ids[2] = nbr_id(1, c, pos, b, -1, b, 0);
                    ids[3] = nbr_id(1, c, pos, b, 0, b, 0);
                end
                default:
                begin
                    ids[0] = nbr_id(0, 0, pos, b, -1, c, -1);
                    ids[1] = nbr_id(0, 0, pos, b, 0, c, -1);
                    ids[2] = nbr_id(0, 0, pos, b, -1, c, 0);
                    ids[3] = nbr_id(0, 0, pos, b, 0, c, 0);
                end
            endcase
            // Face-edge and edge-face runs carry the two orthogonal axes.
            if (q.action == ACT_FACE_EDGES || q.action == ACT_EDGE_FACES)
            begin
                axes[0] = 2'(b + 1);
                axes[1] = 2'(b + 1);
                axes[2] = 2'(c + 1);
                axes[3] = 2'(c + 1);
            end
            for (int k = 0; k < n; k++)
                if (ids[k] != 32'hFFFF_FFFF) valid++;
        end
        for (int k = 0; k < n; k++)
        begin
            e.nid = ids[k];
            e.nax = axes[k];
            e.slot = 3'(k);
            e.vcount = (k == n - 1) ? 3'(valid) : 3'd0;
            e.bad = bad;
            e.last = (k == n - 1);
            expected_nbrs.push_back(e);
        end
    endtask

    // Driver: bursts of random length separated by random gaps. The prediction
    // is made at acceptance, so the grid it sees is the one the block sees.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.action <= '0;
            req.axis <= '0;
            req.entity_id <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_neighbors('{req.action, req.axis, req.entity_id});
                queries_sent++;
            end
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (pending_queries.size() > 0)
                begin
                    query_t q;
                    q = pending_queries.pop_front();
                    req.valid <= 1'b1;
                    req.action <= q.action;
                    req.axis <= q.axis;
                    req.entity_id <= q.entity_id;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor: the stall pattern alternates between phases of always-ready,
    // light stalling and heavy stalling.
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                nbr_t got;
                nbr_t exp_nbr;
                got = '{rsp.neighbour_id, rsp.neighbour_axis, rsp.slot, rsp.valid_count,
                        rsp.bad_request, rsp.last};
                if (expected_nbrs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected beat id=%0d ax=%0d slot=%0d", $realtime,
                                 got.nid, got.nax, got.slot);
                end
                else
                begin
                    exp_nbr = expected_nbrs.pop_front();
                    beats_checked++;
                    if (got !== exp_nbr)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch exp id=%0d ax=%0d slot=%0d cnt=%0d bad=%0b last=%0b",
                                     $realtime, exp_nbr.nid, exp_nbr.nax, exp_nbr.slot,
                                     exp_nbr.vcount, exp_nbr.bad, exp_nbr.last);
                            $display("    got id=%0d ax=%0d slot=%0d cnt=%0d bad=%0b last=%0b",
                                     got.nid, got.nax, got.slot, got.vcount, got.bad,
                                     got.last);
                        end
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            else
                mode_left--;
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 3) != 0);
                default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CELLS_X: grid_x = val;
            CFG_CELLS_Y: grid_y = val;
            CFG_CELLS_Z: grid_z = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y,
                            input logic [DIM_W-1:0] z);
        write_reg(CFG_CELLS_X, x);
        write_reg(CFG_CELLS_Y, y);
        write_reg(CFG_CELLS_Z, z);
    endtask

    // Waits until every queued query is accepted and every response arrived,
    // then covers the block's pipeline depth before the grid may change.
    task automatic drain();
        while (pending_queries.size() > 0 || req.valid || expected_nbrs.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic longint entity_count(input int kind, input int ax);
        longint s[3];
        entity_shape(kind, ax, s);
        return s[0] * s[1] * s[2];
    endfunction

    // Mostly valid ids for the current grid, some at the end or just past it, a few wild.
    function automatic query_t random_query();
        query_t q;
        int kind;
        longint cnt;
        int pick;
        q.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
        q.axis = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        kind = (q.action == ACT_CELL_FACES) ? 0 : (q.action <= ACT_FACE_CELLS ? 1 : 2);
        cnt = entity_count(kind, (q.axis == 0) ? 0 : int'(q.axis) - 1);
        pick = $urandom_range(0, 19);
        if (pick < 15)
            q.entity_id = ID_W'(longint'($urandom) % cnt);
        else if (pick < 18)
            q.entity_id = ID_W'(cnt + $urandom_range(0, 2) - 1);
        else
            q.entity_id = ID_W'($urandom);
        return q;
    endfunction

    initial
    begin
        logic [DIM_W-1:0] gx, gy, gz;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset grid of one cell: every action on the
        // lone cell, the axis ignored for cells, axis zero for faces and
        // edges, unknown actions, and ids at and past the entity count.
        for (int act = 0; act < 8; act++)
            pending_queries.push_back('{3'(act), 2'd1, '0});
        pending_queries.push_back('{ACT_CELL_FACES, 2'd0, '0});
        pending_queries.push_back('{ACT_CELL_FACES, 2'd3, ID_W'(1)});
        pending_queries.push_back('{ACT_FACE_EDGES, 2'd0, '0});
        pending_queries.push_back('{ACT_EDGE_CELLS, 2'd0, '0});
        pending_queries.push_back('{ACT_FACE_CELLS, 2'd2, ID_W'(1)});
        pending_queries.push_back('{ACT_EDGE_FACES, 2'd3, ID_W'(3)});
        pending_queries.push_back('{ACT_EDGE_FACES, 2'd3, ID_W'(4)});
        pending_queries.push_back('{3'd7, 2'd3, {ID_W{1'b1}}});
        pending_queries.push_back('{ACT_FACE_EDGES, 2'd3, {ID_W{1'b1}}});
        drain();

        // Largest grid with a zero and an oversized count, which clamp to one
        // and to the maximum; query the far corners of the largest shapes.
        set_grid(11'd2047, 11'd0, 11'd1024);
        pending_queries.push_back('{ACT_CELL_FACES, 2'd0, ID_W'(1024 * 1024 - 1)});
        pending_queries.push_back('{ACT_EDGE_CELLS, 2'd1, ID_W'(1025 * 2 - 1)});
        pending_queries.push_back('{ACT_EDGE_CELLS, 2'd2, ID_W'(1025 * 1025 * 1 - 1)});
        pending_queries.push_back('{ACT_FACE_CELLS, 2'd1, ID_W'(1025 * 1024 - 1)});
        drain();
        set_grid(11'd1024, 11'd1024, 11'd1024);
        pending_queries.push_back('{ACT_EDGE_FACES, 2'd3, ID_W'(1076890624)});
        pending_queries.push_back('{ACT_FACE_EDGES, 2'd1, ID_W'(1025 * 1024 * 1024 - 1)});
        pending_queries.push_back('{ACT_EDGE_CELLS, 2'd3, ID_W'(1076890625)});
        drain();

        // Random phases, mostly on small grids so that boundaries are common.
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 9)
            begin
                gx = 11'h7FF; gy = 11'h400; gz = 11'h3FF;
            end
            else
            begin
                gx = DIM_W'($urandom_range(1, 5));
                gy = DIM_W'($urandom_range(1, 5));
                gz = DIM_W'($urandom_range(0, 5));
            end
            set_grid(gx, gy, gz);
            // An index past the last register must change nothing.
            write_reg(2'd3, DIM_W'($urandom));
            for (int k = 0; k < 40; k++)
                pending_queries.push_back(random_query());
            drain();
        end
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        $display("Covered %0d queries, %0d neighbor beats checked, on reset, clamped and",
                 queries_sent, beats_checked);
        $display("random grids with boundary, oversized and malformed requests.");
        if (mismatches == 0 && expected_nbrs.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: timeout, %0d beats still expected", expected_nbrs.size());
        $display("tb: done, errors");
        $finish;
    end

endmodule
